>>> rtl/core/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types, register indices and reset values of the score convergence
// monitor.
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int MAX_SHAPES_DEFAULT = 64;
  localparam int CFG_INDEX_W        = 8;
  localparam int CFG_DATA_W         = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_INTERVAL   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WARMUP_LENGTH    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD        = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE             = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_WEIGHT = 8'd4;

  localparam logic [15:0] RST_CHECK_INTERVAL   = 16'd100;
  localparam logic [23:0] RST_WARMUP_LENGTH    = 24'd1000;
  localparam logic [31:0] RST_THRESHOLD        = 32'd1678;
  localparam logic        RST_MODE             = 1'b0;
  localparam logic [15:0] RST_SMOOTHING_WEIGHT = 16'd13107;

  localparam logic MODE_RELATIVE = 1'b0;
  localparam logic MODE_EMA      = 1'b1;

  typedef struct packed {
    logic [23:0] iteration;
    logic [31:0] score;
    logic        last_shape;
  } in_item_t;

  typedef struct packed {
    logic taken;
    logic shape_converged;
    logic stop;
  } out_item_t;

  typedef struct packed {
    logic [15:0] check_interval;
    logic [23:0] warmup_length;
    logic [31:0] threshold;
    logic        mode;
    logic [15:0] smoothing_weight;
  } cfg_t;

  // per-request flags decided at issue
  typedef struct packed {
    logic taken;
    logic accepted;
    logic have_prev;
    logic smooth_rdy;
    logic first;
    logic last;
  } elem_flags_t;

  typedef struct packed {
    logic stopped;
    logic busy;
    logic can_load;
  } dp_status_t;

endpackage

>>> rtl/core/scm_cfg_regs.sv
// ----------------------------------------------------------------------------
// scm_cfg_regs
// Configuration register file: decodes writes by index, masks to width.
// ----------------------------------------------------------------------------
module scm_cfg_regs
  import scm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_interval   <= RST_CHECK_INTERVAL;
      cfg.warmup_length    <= RST_WARMUP_LENGTH;
      cfg.threshold        <= RST_THRESHOLD;
      cfg.mode             <= RST_MODE;
      cfg.smoothing_weight <= RST_SMOOTHING_WEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CHECK_INTERVAL:   cfg.check_interval   <= cfg_data[15:0];
        REG_WARMUP_LENGTH:    cfg.warmup_length    <= cfg_data[23:0];
        REG_THRESHOLD:        cfg.threshold        <= cfg_data[31:0];
        REG_MODE:             cfg.mode             <= cfg_data[0];
        REG_SMOOTHING_WEIGHT: cfg.smoothing_weight <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/scm_ctrl.sv
// ----------------------------------------------------------------------------
// scm_ctrl
// Issue control: element position, vector acceptance, check spacing and
// the history flags; holds a vector start until the datapath drains.
// ----------------------------------------------------------------------------
module scm_ctrl
  import scm_pkg::*;
#(
  parameter int MAX_SHAPES = MAX_SHAPES_DEFAULT,
  parameter int PW = $clog2(MAX_SHAPES + 1),
  parameter int AW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  cfg_t        cfg,
  input  dp_status_t  status,
  output logic        issue_valid,
  output elem_flags_t issue_flags,
  output logic [AW-1:0] issue_addr
);

  logic [PW-1:0]      pos;
  logic               vec_acc;
  logic signed [25:0] last_check;
  logic               have_prev;
  logic               smooth_rdy;

  logic               first;
  logic signed [26:0] since;
  logic               acc_now;
  logic               in_range;

  assign first    = (pos == '0);
  assign since    = $signed({3'b000, in_data.iteration}) - $signed({last_check[25], last_check});
  assign in_range = (pos < PW'(MAX_SHAPES));
  assign acc_now  = first ? (!status.stopped
                             && since >= $signed({11'b0, cfg.check_interval})
                             && in_data.iteration >= cfg.warmup_length)
                          : vec_acc;

  assign in_ready    = status.can_load && !(first && status.busy);
  assign issue_valid = in_valid && in_ready;
  assign issue_addr  = pos[AW-1:0];

  always_comb begin
    issue_flags.taken      = acc_now && in_range;
    issue_flags.accepted   = acc_now;
    issue_flags.have_prev  = have_prev;
    issue_flags.smooth_rdy = smooth_rdy;
    issue_flags.first      = first;
    issue_flags.last       = in_data.last_shape;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      vec_acc    <= 1'b0;
      last_check <= -26'sd1;
      have_prev  <= 1'b0;
      smooth_rdy <= 1'b0;
    end else if (issue_valid) begin
      if (first && acc_now) begin
        last_check <= $signed({2'b00, in_data.iteration});
      end
      if (in_data.last_shape) begin
        if (acc_now) begin
          if (have_prev && cfg.mode == MODE_EMA) begin
            smooth_rdy <= 1'b1;
          end
          have_prev <= 1'b1;
        end
        pos     <= '0;
        vec_acc <= 1'b0;
      end else begin
        vec_acc <= acc_now;
        if (in_range) begin
          pos <= pos + PW'(1);
        end
      end
    end
  end

endmodule

>>> rtl/core/scm_datapath.sv
// ----------------------------------------------------------------------------
// scm_datapath
// Score and EMA memories with a five-stage elastic compare pipeline,
// pass accumulation, sticky stop and the output register.
// ----------------------------------------------------------------------------
module scm_datapath
  import scm_pkg::*;
#(
  parameter int MAX_SHAPES = MAX_SHAPES_DEFAULT,
  parameter int AW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1
)(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          issue_valid,
  input  elem_flags_t   issue_flags,
  input  logic [AW-1:0] issue_addr,
  input  logic [31:0]   issue_score,
  output dp_status_t    status,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data
);

  logic [31:0] prev_mem [MAX_SHAPES];
  logic [31:0] ema_mem  [MAX_SHAPES];

  logic v1, v2, v3, v4, v5;
  logic ld2, ld3, ld4, ld5, ld_out;

  elem_flags_t f1, f2, f3, f4, f5;
  logic [AW-1:0] a1, a2, a3, a4;

  logic [31:0] score1, prev_rd, ema_rd;
  logic [31:0] diff2, ema2;
  logic [32:0] prev_inc2;
  logic [31:0] diff3, ema3;
  logic signed [33:0] op_a3, op_b3;
  logic [31:0] diff4, ema4;
  logic [63:0] prod4;
  logic        rel5;
  logic [31:0] ema5;

  logic        stopped;
  logic        all_passed;

  logic [31:0]        diff1;
  logic signed [32:0] delta2;
  logic signed [67:0] prod3;
  logic signed [49:0] esum4;
  logic [31:0]        ema_new4;
  logic               rel_pass4;
  logic               passed5, all_next, stop_next;

  assign ld_out = v5 && (!out_valid || out_ready);
  assign ld5    = v4 && (!v5 || ld_out);
  assign ld4    = v3 && (!v4 || ld5);
  assign ld3    = v2 && (!v3 || ld4);
  assign ld2    = v1 && (!v2 || ld3);

  assign status.can_load = !v1 || ld2;
  assign status.busy     = v1 || v2 || v3 || v4 || v5;
  assign status.stopped  = stopped;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= issue_valid || (v1 && !ld2);
      v2 <= ld2 || (v2 && !ld3);
      v3 <= ld3 || (v3 && !ld4);
      v4 <= ld4 || (v4 && !ld5);
      v5 <= ld5 || (v5 && !ld_out);
      out_valid <= ld_out || (out_valid && !out_ready);
    end
  end

  // read on issue; the score memory returns the old entry before the write
  always_ff @(posedge clk) begin
    if (issue_valid) begin
      prev_rd <= prev_mem[issue_addr];
      if (issue_flags.taken) begin
        prev_mem[issue_addr] <= issue_score;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_valid) begin
      ema_rd <= ema_mem[issue_addr];
    end
    if (ld5 && f4.taken && f4.have_prev && cfg.mode == MODE_EMA) begin
      ema_mem[a4] <= ema_new4;
    end
  end

  assign diff1  = (score1 >= prev_rd) ? (score1 - prev_rd) : (prev_rd - score1);
  assign delta2 = $signed({1'b0, diff2}) - $signed({1'b0, ema2});
  assign prod3  = op_a3 * op_b3;

  assign esum4     = $signed({2'b00, ema4, 16'h0000}) + $signed(prod4[49:0])
                     + 50'sd32768;
  assign ema_new4  = f4.smooth_rdy ? esum4[47:16] : diff4;
  assign rel_pass4 = ({diff4, 24'h000000} < prod4);

  assign passed5   = f5.taken && f5.have_prev
                     && ((cfg.mode == MODE_EMA) ? ({ema5, 8'h00} < {8'h00, cfg.threshold})
                                                : rel5);
  assign all_next  = (f5.first ? 1'b1 : all_passed)
                     && !(f5.taken && f5.have_prev && !passed5);
  assign stop_next = stopped || (f5.last && f5.accepted && f5.have_prev && all_next);

  always_ff @(posedge clk) begin
    if (issue_valid) begin
      f1     <= issue_flags;
      a1     <= issue_addr;
      score1 <= issue_score;
    end
    if (ld2) begin
      f2        <= f1;
      a2        <= a1;
      diff2     <= diff1;
      ema2      <= ema_rd;
      prev_inc2 <= {1'b0, prev_rd} + 33'd1;
    end
    if (ld3) begin
      f3    <= f2;
      a3    <= a2;
      diff3 <= diff2;
      ema3  <= ema2;
      if (cfg.mode == MODE_EMA) begin
        op_a3 <= $signed({18'h00000, cfg.smoothing_weight});
        op_b3 <= $signed({delta2[32], delta2});
      end else begin
        op_a3 <= $signed({2'b00, cfg.threshold});
        op_b3 <= $signed({1'b0, prev_inc2});
      end
    end
    if (ld4) begin
      f4    <= f3;
      a4    <= a3;
      diff4 <= diff3;
      ema4  <= ema3;
      prod4 <= prod3[63:0];
    end
    if (ld5) begin
      f5   <= f4;
      rel5 <= rel_pass4;
      ema5 <= ema_new4;
    end
    if (ld_out) begin
      out_data.taken           <= f5.taken;
      out_data.shape_converged <= passed5;
      out_data.stop            <= stop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped    <= 1'b0;
      all_passed <= 1'b1;
    end else if (ld_out) begin
      stopped    <= stop_next;
      all_passed <= f5.last ? 1'b1 : all_next;
    end
  end

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stop flag cleared without reset");

  a_stop_shown: assert property (@(posedge clk) disable iff (rst)
    !stopped ##1 stopped |-> out_valid && out_data.stop)
    else $error("stop latched without a result carrying it");

  a_start_drained: assert property (@(posedge clk) disable iff (rst)
    issue_valid && issue_flags.first |-> !status.busy)
    else $error("vector start issued while pipeline busy");

  a_conv_taken: assert property (@(posedge clk) disable iff (rst)
    ld_out |=> !out_data.shape_converged || out_data.taken)
    else $error("shape passed without being taken");

endmodule

>>> rtl/core/score_convergence_monitor_unit.sv
// ----------------------------------------------------------------------------
// score_convergence_monitor_unit
// Early-stopping convergence check over per-shape score vectors.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready, one shape score each, with last_shape
// closing a vector. Every request gives exactly one result on
// out_valid/out_ready: taken, shape_converged and the sticky stop flag.
// Registers are written on cfg_valid/cfg_ready (always ready) by index. The
// user must write them only while the block is idle; the block does not enforce it.
// A result passes through these registered steps in order: memory read, abs
// difference, operand select, shared multiplier, sum and compare, output
// register. Within a vector one request is taken every cycle while the output
// is not stalled; the first request of a vector waits until the pipeline has
// drained, as acceptance depends on the stop flag of the previous vector.
// Reset clears control state and loads register defaults; the score and EMA
// memories are not cleared. A stalled receiver holds the output register and
// the pipeline fills behind it before in_ready falls.
// ----------------------------------------------------------------------------
module score_convergence_monitor_unit
  import scm_pkg::*;
#(
  parameter int MAX_SHAPES = MAX_SHAPES_DEFAULT
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW = $clog2(MAX_SHAPES + 1);
  localparam int AW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;

  cfg_t          cfg;
  dp_status_t    status;
  logic          issue_valid;
  elem_flags_t   issue_flags;
  logic [AW-1:0] issue_addr;

  scm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scm_ctrl #(
    .MAX_SHAPES (MAX_SHAPES),
    .PW         (PW),
    .AW         (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg         (cfg),
    .status      (status),
    .issue_valid (issue_valid),
    .issue_flags (issue_flags),
    .issue_addr  (issue_addr)
  );

  scm_datapath #(
    .MAX_SHAPES (MAX_SHAPES),
    .AW         (AW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .issue_valid (issue_valid),
    .issue_flags (issue_flags),
    .issue_addr  (issue_addr),
    .issue_score (in_data.score),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
